FILE: sv/fena_pkg.sv
// Shared constants and types of the fire-effect neighbor average block.
// Used by every module of the block but fena_ram; depends on nothing.
`timescale 1ns / 1ps

package fena_pkg;

    // Frame geometry of the incoming raster
    localparam int FRAME_WIDTH  = 256;
    localparam int FRAME_HEIGHT = 192;

    localparam int COL_W  = $clog2(FRAME_WIDTH);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    localparam int MAX_CR = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CALC_W = (MAX_CR > 8) ? MAX_CR : 8;

    localparam int PIX_W     = 16;
    localparam int OUT_PIX_W = 13;
    localparam int COORD_W   = 8;
    localparam int SUM_SHIFT = 3;

    // Both line stores share one RAM word: {row two above, row just above}
    localparam int LINE_W = 2 * PIX_W;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - OUT_PIX_W - 2 * COORD_W;

    // Output queue
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_AW    = 2;

    // Item in the compute stage, in the cycle after acceptance
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } stage_t;

    // Result item
    typedef struct packed {
        logic                 frame_last;
        logic [COORD_W-1:0]   out_col;
        logic [COORD_W-1:0]   out_row;
        logic [OUT_PIX_W-1:0] pixel_out;
    } out_item_t;

endpackage

FILE: sv/fena_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module fena_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fena_win.sv
// 3x3 window registers, eight-neighbor sum and output position logic.
// Depends on fena_pkg.
`timescale 1ns / 1ps

module fena_win (
    input  logic                      aclk,
    input  fena_pkg::stage_t          st,
    input  logic [fena_pkg::PIX_W-1:0] top,
    input  logic [fena_pkg::PIX_W-1:0] mid,
    output logic                      res_valid,
    output fena_pkg::out_item_t       res
);

    // [0],[1]: top row, columns x-2 and x-1; [2],[3] middle; [4],[5] bottom
    logic [fena_pkg::PIX_W-1:0] win_reg [6];

    logic [fena_pkg::PIX_W-1:0]  sum_a, sum_b, sum;
    logic [fena_pkg::CALC_W-1:0] col_ext, row_ext;
    logic                        in_rows, in_cols;

    always_ff @(posedge aclk) begin
        if (st.valid) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= st.pixel;
        end
    end

    always_comb begin
        sum_a = win_reg[0] + top + win_reg[2] + win_reg[3];
        sum_b = mid + win_reg[4] + win_reg[5] + st.pixel;
        sum   = sum_a + sum_b;

        col_ext = fena_pkg::CALC_W'(st.col);
        row_ext = fena_pkg::CALC_W'(st.row);

        in_rows = (row_ext >= fena_pkg::CALC_W'(2))
               && (row_ext <= fena_pkg::CALC_W'(fena_pkg::FRAME_HEIGHT - 2));
        in_cols = (col_ext >= fena_pkg::CALC_W'(2));

        res_valid     = st.valid && in_rows && in_cols;
        res.pixel_out = sum[fena_pkg::PIX_W-1:fena_pkg::SUM_SHIFT];
        res.out_row   = fena_pkg::COORD_W'(row_ext - fena_pkg::CALC_W'(2));
        res.out_col   = fena_pkg::COORD_W'(col_ext - fena_pkg::CALC_W'(1));
        res.frame_last = (row_ext == fena_pkg::CALC_W'(fena_pkg::FRAME_HEIGHT - 2))
                      && (col_ext == fena_pkg::CALC_W'(fena_pkg::FRAME_WIDTH - 1));
    end

endmodule

FILE: sv/fena_outq.sv
// Three-entry output queue in flip-flops; decouples compute from the m_ side.
// Depends on fena_pkg.
`timescale 1ns / 1ps

module fena_outq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  fena_pkg::out_item_t           push_item,
    output logic                          pop_valid,
    input  logic                          pop_ready,
    output fena_pkg::out_item_t           pop_item,
    output logic [fena_pkg::OUTQ_AW-1:0]  level
);

    fena_pkg::out_item_t entry_reg [fena_pkg::OUTQ_DEPTH];

    logic [fena_pkg::OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fena_pkg::OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fena_pkg::OUTQ_AW-1:0] cnt_reg, cnt_next;
    logic                         pop;

    localparam logic [fena_pkg::OUTQ_AW-1:0] LAST_PTR =
        fena_pkg::OUTQ_AW'(fena_pkg::OUTQ_DEPTH - 1);

    assign pop = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign level     = cnt_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && cnt_reg == fena_pkg::OUTQ_AW'(fena_pkg::OUTQ_DEPTH)))
        else $error("output queue overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("output queue pointers disagree with count");
`endif

endmodule

FILE: sv/fire_effect_neighbor_average_top.sv
// Top level of the fire-effect neighbor average filter.
// Depends on fena_pkg, fena_ram, fena_win and fena_outq.
`timescale 1ns / 1ps

// Takes the previous frame one 16-bit pixel per item in raster order and
// returns, for every interior position (row 0..FRAME_HEIGHT-4, column
// 1..FRAME_WIDTH-2), the sum of its eight neighbors (left, right, and the
// three pixels of each of the next two rows), wrapped to 16 bits and
// shifted right by 3. The result for (r,c) leaves once pixel (r+2,c+1) has
// come in, so results come out in raster order; border positions and the
// bottom input row give nothing. s_tuser marks the first pixel of a frame
// and restarts the row and column counters; without it the counters wrap
// after the last pixel of the frame. Throughput is one item per clock,
// sustained, as long as m_tready stays high. A result passes the pixel
// register (the line-store RAM read shares its accepting edge) and is
// then written into the output queue, from which the m_ side takes it.
// The two previous rows live in one FRAME_WIDTH x 32-bit RAM, read at
// the pixel's column as it enters and rewritten by the compute stage
// in the next cycle; a back-to-back hit on the same column is forwarded
// around the RAM. There is no clearing pass: stale line-store contents
// never reach a result. A three-entry output queue absorbs stalls on the
// m_ side; s_tready drops only when the queue and the compute stage hold
// three items between them.
module fire_effect_neighbor_average_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_in
    input  logic        s_tuser,   // frame_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] pixel_out, [20:13] out_row,
                                   // [28:21] out_col, [31:29] zero
    output logic        m_tlast    // frame_last
);

    logic accept;

    // Raster position of the next pixel
    logic [fena_pkg::COL_W-1:0] col_reg, col_next;
    logic [fena_pkg::ROW_W-1:0] row_reg, row_next;
    logic [fena_pkg::COL_W-1:0] cur_col;
    logic [fena_pkg::ROW_W-1:0] cur_row;

    // Compute stage
    logic                       p1_valid_reg;
    logic [fena_pkg::PIX_W-1:0] p1_pix_reg;
    logic [fena_pkg::COL_W-1:0] p1_col_reg;
    logic [fena_pkg::ROW_W-1:0] p1_row_reg;
    fena_pkg::stage_t           st;

    // Line store RAM and forwarding
    logic [fena_pkg::LINE_W-1:0] ram_rdata, ram_wdata, line_word;
    logic                        fwd_hit_reg, fwd_hit_next;
    logic [fena_pkg::LINE_W-1:0] fwd_data_reg;
    logic [fena_pkg::PIX_W-1:0]  top_pix, mid_pix;

    logic                         res_valid;
    fena_pkg::out_item_t          res_item, q_item;
    logic [fena_pkg::OUTQ_AW-1:0] q_level;

    assign accept = s_tvalid && s_tready;

    // frame_start takes effect on the pixel that carries it
    assign cur_col = s_tuser ? '0 : col_reg;
    assign cur_row = s_tuser ? '0 : row_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (cur_col == fena_pkg::COL_W'(fena_pkg::FRAME_WIDTH - 1)) begin
                col_next = '0;
                row_next = (cur_row == fena_pkg::ROW_W'(fena_pkg::FRAME_HEIGHT - 1))
                         ? '0 : cur_row + 1'b1;
            end else begin
                col_next = cur_col + 1'b1;
                row_next = cur_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            p1_valid_reg <= accept;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pix_reg <= s_tdata[fena_pkg::PIX_W-1:0];
            p1_col_reg <= cur_col;
            p1_row_reg <= cur_row;
        end
        fwd_data_reg <= ram_wdata;
    end

    // Same column written by the compute stage while the new pixel reads it
    assign fwd_hit_next = accept && p1_valid_reg && (p1_col_reg == cur_col);

    assign line_word = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign top_pix   = line_word[fena_pkg::LINE_W-1:fena_pkg::PIX_W];
    assign mid_pix   = line_word[fena_pkg::PIX_W-1:0];

    // rows move up by one: old middle becomes top, new pixel becomes middle
    assign ram_wdata = {mid_pix, p1_pix_reg};

    fena_ram #(
        .WIDTH (fena_pkg::LINE_W),
        .DEPTH (fena_pkg::FRAME_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_col_reg),
        .wdata (ram_wdata),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    always_comb begin
        st.valid = p1_valid_reg;
        st.pixel = p1_pix_reg;
        st.col   = p1_col_reg;
        st.row   = p1_row_reg;
    end

    fena_win u_win (
        .aclk      (aclk),
        .st        (st),
        .top       (top_pix),
        .mid       (mid_pix),
        .res_valid (res_valid),
        .res       (res_item)
    );

    fena_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_item (res_item),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_item  (q_item),
        .level     (q_level)
    );

    // room for the item in the compute stage plus the one being accepted
    assign s_tready = (3'(q_level) + 3'(p1_valid_reg))
                   <= 3'(fena_pkg::OUTQ_DEPTH - 1);

    assign m_tdata = {fena_pkg::M_PAD_W'(0), q_item.out_col, q_item.out_row,
                      q_item.pixel_out};
    assign m_tlast = q_item.frame_last;

`ifndef SYNTHESIS
    a_stage_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted item did not enter the compute stage");

    a_start_restarts_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |=> (col_reg == fena_pkg::COL_W'(1) && row_reg == '0))
        else $error("frame start did not restart the counters");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (q_item.out_row == fena_pkg::COORD_W'(fena_pkg::FRAME_HEIGHT - 4)))
        else $error("frame_last on a row other than the last output row");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fena_pkg::CALC_W'(col_reg) <= fena_pkg::CALC_W'(fena_pkg::FRAME_WIDTH - 1))
        else $error("column counter out of range");
`endif

endmodule

FILE: tb/tb_fire_effect_neighbor_average_top.sv
// Self-checking testbench for fire_effect_neighbor_average_top: raster pixels in, averages out.
// Depends on fena_pkg and the block's RTL; it keeps its own copy of the line stores and window.
`timescale 1ns / 1ps

module tb_fire_effect_neighbor_average_top;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int LONG_HOLD      = 300;   // cycles the receiver holds off in the pressure test
    localparam int RANDOM_ITEMS   = 400;
    localparam int SHOWN_MAX      = 10;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] pixel_in
    logic        s_tuser  = 1'b0; // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [12:0] pixel_out, [20:13] out_row, [28:21] out_col, [31:29] 0
    logic        m_tlast;         // frame_last

    fire_effect_neighbor_average_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 20 ns period, starts low so time zero carries no edge
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: the two rows above, the 3x2 window of the two
    // previous columns, and the position of the next pixel.
    // ---------------------------------------------------------------
    logic [fena_pkg::PIX_W-1:0] two_rows_up [fena_pkg::FRAME_WIDTH];
    logic [fena_pkg::PIX_W-1:0] one_row_up  [fena_pkg::FRAME_WIDTH];
    logic [fena_pkg::PIX_W-1:0] win [6];    // [row*2] = column x-2, [row*2+1] = column x-1
    int unsigned                next_col = 0;
    int unsigned                next_row = 0;
    fena_pkg::out_item_t        averages_due [$];

    int pixels_sent   = 0;
    int averages_seen = 0;
    int frame_ends    = 0;
    int mismatches    = 0;

    // Idling knobs: sender gap is used by the stimulus process only,
    // stall percentage and hold requests are read by the receiver.
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    // Works out the result (if any) caused by one accepted pixel.
    function automatic void predict_average(input logic [fena_pkg::PIX_W-1:0] pix,
                                            input logic restart);
        int unsigned                x;
        int unsigned                y;
        logic [fena_pkg::PIX_W-1:0] top;
        logic [fena_pkg::PIX_W-1:0] mid;
        logic [fena_pkg::PIX_W-1:0] sum;
        fena_pkg::out_item_t        avg;
        if (restart) begin
            next_col = 0;
            next_row = 0;
        end
        x   = next_col;
        y   = next_row;
        top = two_rows_up[x];
        mid = one_row_up[x];
        // interior position (y-2, x-1) completes once (y, x) arrives
        if (y >= 2 && y <= fena_pkg::FRAME_HEIGHT - 2 && x >= 2) begin
            sum = win[0] + top + win[2] + win[3] + mid + win[4] + win[5] + pix;  // wraps at 16 bits
            avg.pixel_out  = fena_pkg::OUT_PIX_W'(sum >> fena_pkg::SUM_SHIFT);
            avg.out_row    = fena_pkg::COORD_W'(y - 2);
            avg.out_col    = fena_pkg::COORD_W'(x - 1);
            avg.frame_last = (y == fena_pkg::FRAME_HEIGHT - 2 && x == fena_pkg::FRAME_WIDTH - 1);
            averages_due.push_back(avg);
        end
        two_rows_up[x] = mid;
        one_row_up[x]  = pix;
        win[0] = win[1];
        win[1] = top;
        win[2] = win[3];
        win[3] = mid;
        win[4] = win[5];
        win[5] = pix;
        x++;
        if (x >= fena_pkg::FRAME_WIDTH) begin
            x = 0;
            y++;
            if (y >= fena_pkg::FRAME_HEIGHT) y = 0;
        end
        next_col = x;
        next_row = y;
    endfunction

    // Mix of extremes, small values (sum does not wrap) and full-range words
    function automatic logic [fena_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2, 3:    return fena_pkg::PIX_W'($urandom_range(8191));
            default: return fena_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // Offers one item, with random gaps before it; returns at the edge that takes it.
    task automatic push_pixel(input logic [fena_pkg::PIX_W-1:0] pix, input logic restart);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_average(pix, restart);
        pixels_sent++;
    endtask

    task automatic set_idling(input int gap, input int stall);
        send_gap_pct = gap;
        stall_pct   <= stall;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < SHOWN_MAX)
            $display("mismatch on %s at result %0d: expected %0h, got %0h",
                     what, averages_seen, want, got);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, or a long hold when one is requested
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            m_tready  <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin : check_results
        fena_pkg::out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (averages_due.size() == 0) begin
                report_mismatch("unexpected result", '0, m_tdata);
            end else begin
                want = averages_due.pop_front();
                if (m_tdata[12:0] !== want.pixel_out)
                    report_mismatch("pixel_out", 32'(want.pixel_out), 32'(m_tdata[12:0]));
                if (m_tdata[20:13] !== want.out_row)
                    report_mismatch("out_row", 32'(want.out_row), 32'(m_tdata[20:13]));
                if (m_tdata[28:21] !== want.out_col)
                    report_mismatch("out_col", 32'(want.out_col), 32'(m_tdata[28:21]));
                if (m_tdata[31:29] !== 3'b000)
                    report_mismatch("tdata padding", '0, 32'(m_tdata[31:29]));
                if (m_tlast !== want.frame_last)
                    report_mismatch("frame_last", 32'(want.frame_last), 32'(m_tlast));
                if (want.frame_last) frame_ends++;
                averages_seen++;
            end
        end
    end

    // Watchdog: too long with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_fire_effect_neighbor_average_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Saturated rows give the largest sum (wraps, max output), then a run
    // of alternating corner values in the first result row.
    task automatic test_extremes();
        logic [fena_pkg::PIX_W-1:0] corner [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
        push_pixel(16'hFFFF, 1'b1);
        for (int i = 1; i < 2 * fena_pkg::FRAME_WIDTH + 64; i++) push_pixel(16'hFFFF, 1'b0);
        for (int i = 0; i < 64; i++) push_pixel(corner[i % 4], 1'b0);
    endtask

    // frame_start ahead of time: once mid-row while results flow, twice
    // before any result; stale line stores and window must not leak out.
    task automatic test_early_restart();
        push_pixel(rand_pixel(), 1'b1);
        for (int i = 1; i < 30; i++) push_pixel(rand_pixel(), 1'b0);
        push_pixel(rand_pixel(), 1'b1);
        for (int i = 1; i < 20; i++) push_pixel(rand_pixel(), 1'b0);
        push_pixel(rand_pixel(), 1'b1);
        for (int i = 1; i < 2 * fena_pkg::FRAME_WIDTH + 10; i++) push_pixel(rand_pixel(), 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering, so the output
    // queue fills and s_tready has to drop.
    task automatic test_back_pressure();
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        for (int i = 0; i < 150; i++) push_pixel(rand_pixel(), 1'b0);
    endtask

    // Random content across the four idling mixes, results flowing throughout
    task automatic test_random_traffic();
        int gap_of   [4] = '{0, 68, 0, 34};
        int stall_of [4] = '{0, 0, 68, 34};
        for (int p = 0; p < 4; p++) begin
            set_idling(gap_of[p], stall_of[p]);
            for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
                push_pixel(rand_pixel(), 1'b0);
            end
        end
    endtask

    initial begin : run_tests
        for (int i = 0; i < fena_pkg::FRAME_WIDTH; i++) begin
            two_rows_up[i] = '0;
            one_row_up[i]  = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_back_pressure();
        test_random_traffic();
        test_early_restart();

        s_tvalid <= 1'b0;
        // drain; the watchdog bounds this wait
        while (averages_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d pixels in, %0d averages checked, %0d frame ends, %0d mismatches",
                 pixels_sent, averages_seen, frame_ends, mismatches);
        $display("saturated and corner values, long output hold, four idling mixes, early restarts");
        if (mismatches == 0 && averages_due.size() == 0) begin
            $display("tb_fire_effect_neighbor_average_top: clean");
        end else begin
            $display("tb_fire_effect_neighbor_average_top: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/fena_pkg.sv
sv/fena_ram.sv
sv/fena_win.sv
sv/fena_outq.sv
sv/fire_effect_neighbor_average_top.sv
tb/tb_fire_effect_neighbor_average_top.sv
